@@ hw/rtl/rgbhls_pkg.sv @@
`timescale 1ns / 1ps
// Package for the RGB to HLS converter: transaction payload types, cell data and constants.
// No dependencies.
package rgbhls_pkg;

	localparam int ChanBits  = 16;
	localparam int HueBits   = 15;
	localparam int SumBits   = 18;
	localparam int PosBits   = 20;
	localparam int RemBits   = 34;
	localparam int QuoBits   = 16;
	localparam int NumCells  = QuoBits;
	localparam int NumLanes  = 3;

	localparam logic [ChanBits-1:0] FullScale = '1;
	localparam logic [SumBits-1:0]  ThreeFull = SumBits'(3 * ((1 << ChanBits) - 1));
	localparam logic [11:0]         HueUnit   = 12'd3840;
	// ceil(2^19 / 3): exact floor(sum / 3) for any 18-bit sum
	localparam logic [17:0]         RecipThree = 18'd174763;
	localparam int                  RecipShift = 19;

	localparam int LaneHue  = 0;
	localparam int LaneSatA = 1;
	localparam int LaneSatB = 2;

	typedef struct packed {
		logic [ChanBits-1:0] red_in;
		logic [ChanBits-1:0] green_in;
		logic [ChanBits-1:0] blue_in;
	} pix_t;

	typedef struct packed {
		logic [HueBits-1:0]  hue_out;
		logic [ChanBits-1:0] light_out;
		logic [ChanBits-1:0] sat_out;
	} res_t;

	typedef struct packed {
		logic [RemBits-1:0] rem;
		logic [RemBits-1:0] dsh;
		logic [QuoBits-1:0] quo;
	} div_lane_t;

	typedef struct packed {
		div_lane_t [NumLanes-1:0] lane;
		logic [ChanBits-1:0]      light;
		logic                     grey;
	} cell_data_t;

endpackage

@@ hw/rtl/rgbhls_div_cell.sv @@
`timescale 1ns / 1ps
// One cell of the divider chain: one quotient bit for each of the three lanes.
// Depends on rgbhls_pkg.
module rgbhls_div_cell
	import rgbhls_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       adv,
	input  logic       valid_in,
	input  cell_data_t data_in,
	output logic       valid,
	output cell_data_t data
);

	logic       valid_q;
	cell_data_t data_q;
	cell_data_t data_nxt;

	always_comb begin
		data_nxt = data_in;
		for (int j = 0; j < NumLanes; j++) begin
			if (data_in.lane[j].rem >= data_in.lane[j].dsh) begin
				data_nxt.lane[j].rem = data_in.lane[j].rem - data_in.lane[j].dsh;
				data_nxt.lane[j].quo = {data_in.lane[j].quo[QuoBits-2:0], 1'b1};
			end else begin
				data_nxt.lane[j].quo = {data_in.lane[j].quo[QuoBits-2:0], 1'b0};
			end
			data_nxt.lane[j].dsh = data_in.lane[j].dsh >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_q <= data_nxt;
		end
	end

	assign valid = valid_q;
	assign data  = data_q;

endmodule

@@ hw/rtl/rgb_to_hls_convert_top.sv @@
`timescale 1ns / 1ps
// Top level of the RGB to HLS converter: front stages, divider cell chain, output register.
// Depends on rgbhls_pkg and rgbhls_div_cell.
//
// Input channel pix / pix_valid / pix_stall carries one RGB pixel per transaction,
// output channel res / res_valid / res_stall one hue, lightness, saturation result.
// A transaction moves at a clock edge where valid is high and stall is low.
// res_valid rises once the pixel has passed 19 register stages: a stage finding max, min
// and sums, a stage of multipliers, 16 divider cells giving one quotient bit each for the
// hue and both saturation quotients, and the output register, the first of them loaded
// at the edge that accepts the pixel.
// Throughput is one pixel per cycle while pix_stall is low. Each stage advances when it is empty or the
// stage after it advances, so bubbles close up; pix_stall rises only when every stage
// holds a pixel and the receiver stalls. While stalled, res holds steady.
// Reset empties the pipeline; no pixel in flight survives it.
module rgb_to_hls_convert_top
	import rgbhls_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic pix_valid,
	output logic pix_stall,
	input  pix_t pix,
	output logic res_valid,
	input  logic res_stall,
	output res_t res
);

	localparam int NumStages = NumCells + 3;

	logic [NumStages-1:0] v;
	logic [NumStages:0]   en;

	// stage 1
	logic                v_s1;
	logic [SumBits-1:0]  sum_s1, num1_s1, num2_s1, den2_s1;
	logic [ChanBits-1:0] span_s1;
	logic [PosBits-1:0]  pos_s1;
	logic                grey_s1;

	logic [ChanBits-1:0] r, g, b, hi, lo;
	logic [1:0]          which;
	logic [SumBits-1:0]  sum;
	logic [PosBits-1:0]  span_w, pos;

	assign r = pix.red_in;
	assign g = pix.green_in;
	assign b = pix.blue_in;
	assign sum = SumBits'(r) + SumBits'(g) + SumBits'(b);

	always_comb begin
		hi = r;
		lo = r;
		which = 2'd0;
		if (g > hi) begin
			hi = g;
			which = 2'd1;
		end else if (g < lo) begin
			lo = g;
		end
		if (b > hi) begin
			hi = b;
			which = 2'd2;
		end else if (b < lo) begin
			lo = b;
		end
		span_w = PosBits'(hi - lo);
		case (which)
			2'd0: begin
				if (g >= b) pos = PosBits'(g) - PosBits'(b);
				else pos = PosBits'(6) * span_w - (PosBits'(b) - PosBits'(g));
			end
			2'd1: pos = PosBits'(2) * span_w + PosBits'(b) - PosBits'(r);
			default: pos = PosBits'(4) * span_w + PosBits'(r) - PosBits'(g);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en[0]) begin
			v_s1 <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			sum_s1  <= sum;
			num1_s1 <= sum - SumBits'(3) * SumBits'(lo);
			num2_s1 <= SumBits'(3) * SumBits'(hi) - sum;
			den2_s1 <= ThreeFull - sum;
			span_s1 <= hi - lo;
			pos_s1  <= pos;
			grey_s1 <= (hi == lo);
		end
	end

	// stage 2: products, divisors aligned to the top quotient bit
	logic       v_s2;
	cell_data_t cd_s2;
	logic [2*SumBits-1:0] light_prod;

	assign light_prod = (2*SumBits)'(sum_s1) * (2*SumBits)'(RecipThree);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en[1]) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			cd_s2.lane[LaneHue].rem  <= RemBits'(pos_s1) * RemBits'(HueUnit);
			cd_s2.lane[LaneHue].dsh  <= RemBits'(span_s1) << (QuoBits - 1);
			cd_s2.lane[LaneHue].quo  <= '0;
			cd_s2.lane[LaneSatA].rem <= RemBits'(num1_s1) * RemBits'(FullScale);
			cd_s2.lane[LaneSatA].dsh <= RemBits'(sum_s1) << (QuoBits - 1);
			cd_s2.lane[LaneSatA].quo <= '0;
			cd_s2.lane[LaneSatB].rem <= RemBits'(num2_s1) * RemBits'(FullScale);
			cd_s2.lane[LaneSatB].dsh <= RemBits'(den2_s1) << (QuoBits - 1);
			cd_s2.lane[LaneSatB].quo <= '0;
			cd_s2.light <= light_prod[RecipShift +: ChanBits];
			cd_s2.grey  <= grey_s1;
		end
	end

	// divider chain
	logic       cv [NumCells+1];
	cell_data_t cd [NumCells+1];

	assign cv[0] = v_s2;
	assign cd[0] = cd_s2;

	for (genvar k = 0; k < NumCells; k++) begin : g_cell
		rgbhls_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (en[k+2]),
			.valid_in (cv[k]),
			.data_in  (cd[k]),
			.valid    (cv[k+1]),
			.data     (cd[k+1])
		);
		assign v[k+2] = cv[k+1];
	end

	// output register
	logic                res_valid_q;
	res_t                res_q;
	logic [QuoBits-1:0]  sat_a, sat_b, sat_m;

	assign sat_a = cd[NumCells].lane[LaneSatA].quo;
	assign sat_b = cd[NumCells].lane[LaneSatB].quo;
	assign sat_m = (sat_a > sat_b) ? sat_a : sat_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (en[NumStages-1]) begin
			res_valid_q <= cv[NumCells];
		end
	end

	always_ff @(posedge clk) begin
		if (en[NumStages-1]) begin
			res_q.light_out <= cd[NumCells].light;
			if (cd[NumCells].grey) begin
				res_q.hue_out <= '0;
				res_q.sat_out <= '0;
			end else begin
				res_q.hue_out <= cd[NumCells].lane[LaneHue].quo[HueBits-1:0];
				res_q.sat_out <= sat_m;
			end
		end
	end

	assign v[0] = v_s1;
	assign v[1] = v_s2;
	assign v[NumStages-1] = res_valid_q;

	assign en[NumStages] = !res_stall;
	for (genvar k = 0; k < NumStages; k++) begin : g_en
		assign en[k] = !v[k] || en[k+1];
	end

	assign pix_stall = !en[0];
	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

@@ hw/rtl/rgbhls_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the RGB to HLS converter, bound to the top level.
// Depends on rgbhls_pkg.
module rgbhls_checker
	import rgbhls_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic pix_valid,
	input logic pix_stall,
	input pix_t pix,
	input logic res_valid,
	input logic res_stall,
	input res_t res
);

	a_pix_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && pix_stall |=> pix_valid && $stable(pix))
		else $error("stalled input transaction changed");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("result dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> $stable(res))
		else $error("stalled result changed");

	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.hue_out <= HueBits'(23039))
		else $error("hue out of range");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall |-> res_valid && res_stall)
		else $error("input stalled with room in pipeline");

endmodule

bind rgb_to_hls_convert_top rgbhls_checker u_rgbhls_checker (.*);

@@ tb/sv/tb_rgb_to_hls_convert_top.sv @@
`timescale 1ns / 1ps
// Testbench for rgb_to_hls_convert_top: directed table then random pixels, checked
// against an integer colour-conversion predictor. Depends on rgbhls_pkg and the RTL.
module tb_rgb_to_hls_convert_top;
	import rgbhls_pkg::*;

	localparam int LatencyCycles = 19;
	localparam int WatchdogLimit = 4000;
	localparam int NumRandom     = 1400;
	localparam int NumDirected   = 20;

	logic clk;
	logic arst_n;
	logic pix_valid;
	logic pix_stall;
	pix_t pix;
	logic res_valid;
	logic res_stall;
	res_t res;

	res_t pending_hls[$];
	int   n_fail;
	int   idle_cycles;
	bit   no_idle;

	rgb_to_hls_convert_top dut (
		.clk(clk), .arst_n(arst_n),
		.pix_valid(pix_valid), .pix_stall(pix_stall), .pix(pix),
		.res_valid(res_valid), .res_stall(res_stall), .res(res)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic res_t convert_hls(pix_t p);
		longint unsigned r, g, b, sum, hi, lo, span, s1, s2, sat, pos, hue, fs;
		int which;
		res_t o;
		fs = 65535;
		r = p.red_in;
		g = p.green_in;
		b = p.blue_in;
		sum = r + g + b;
		hi = r;
		lo = r;
		which = 0;
		hue = 0;
		sat = 0;
		if (g > hi) begin
			hi = g;
			which = 1;
		end else if (g < lo) begin
			lo = g;
		end
		if (b > hi) begin
			hi = b;
			which = 2;
		end else if (b < lo) begin
			lo = b;
		end
		if (hi != lo) begin
			span = hi - lo;
			s1 = (fs * (sum - 3 * lo)) / sum;
			s2 = (fs * (3 * hi - sum)) / (3 * fs - sum);
			sat = (s1 > s2) ? s1 : s2;
			if (sat > fs)
				sat = fs;
			if (which == 0)
				pos = (g >= b) ? g - b : 6 * span - (b - g);
			else if (which == 1)
				pos = 2 * span + b - r;
			else
				pos = 4 * span + r - g;
			hue = (3840 * pos) / span;
		end
		o.hue_out   = hue[HueBits-1:0];
		o.light_out = 16'(sum / 3);
		o.sat_out   = sat[15:0];
		return o;
	endfunction

	// rows with known clear take the predictor
	typedef struct packed {
		pix_t p;
		logic known;
		res_t r;
	} dir_row_t;

	dir_row_t dir_tab[NumDirected];

	initial begin
		dir_tab[0]  = '{'{16'd0, 16'd0, 16'd0}, 1'b1, '{15'd0, 16'd0, 16'd0}};
		dir_tab[1]  = '{'{16'hFFFF, 16'hFFFF, 16'hFFFF}, 1'b1, '{15'd0, 16'hFFFF, 16'd0}};
		dir_tab[2]  = '{'{16'hFFFF, 16'd0, 16'd0}, 1'b1, '{15'd0, 16'd21845, 16'hFFFF}};
		dir_tab[3]  = '{'{16'd0, 16'hFFFF, 16'd0}, 1'b1, '{15'd7680, 16'd21845, 16'hFFFF}};
		dir_tab[4]  = '{'{16'd0, 16'd0, 16'hFFFF}, 1'b1, '{15'd15360, 16'd21845, 16'hFFFF}};
		dir_tab[5]  = '{'{16'hFFFF, 16'hFFFF, 16'd0}, 1'b1, '{15'd3840, 16'd43690, 16'hFFFF}};
		dir_tab[6]  = '{'{16'd0, 16'hFFFF, 16'hFFFF}, 1'b1, '{15'd11520, 16'd43690, 16'hFFFF}};
		dir_tab[7]  = '{'{16'hFFFF, 16'd0, 16'hFFFF}, 1'b1, '{15'd19200, 16'd43690, 16'hFFFF}};
		dir_tab[8]  = '{'{16'd1234, 16'd1234, 16'd1234}, 1'b1, '{15'd0, 16'd1234, 16'd0}};
		dir_tab[9]  = '{'{16'hFFFF, 16'd0, 16'd1}, 1'b0, '0};
		dir_tab[10] = '{'{16'hFFFF, 16'hFFFE, 16'hFFFF}, 1'b0, '0};
		dir_tab[11] = '{'{16'd1, 16'd0, 16'd0}, 1'b0, '0};
		dir_tab[12] = '{'{16'd0, 16'd0, 16'd1}, 1'b0, '0};
		dir_tab[13] = '{'{16'hFFFE, 16'hFFFF, 16'hFFFE}, 1'b0, '0};
		dir_tab[14] = '{'{16'h8000, 16'h8000, 16'h7FFF}, 1'b0, '0};
		dir_tab[15] = '{'{16'h5555, 16'hAAAA, 16'hAAAA}, 1'b0, '0};
		dir_tab[16] = '{'{16'hAAAA, 16'h5555, 16'hAAAA}, 1'b0, '0};
		dir_tab[17] = '{'{16'h1234, 16'hFEDC, 16'h8001}, 1'b0, '0};
		dir_tab[18] = '{'{16'hFFFF, 16'h0001, 16'h0002}, 1'b0, '0};
		dir_tab[19] = '{'{16'h7FFF, 16'h0000, 16'h7FFF}, 1'b0, '0};
	end

	function automatic bit take_gap();
		return !no_idle && ($urandom_range(99) < 27);
	endfunction

	// valid stays high on return; the caller drops it when the stream pauses
	task automatic send_pixel(pix_t p, res_t want);
		while (take_gap()) begin
			pix_valid <= 1'b0;
			@(posedge clk);
		end
		pix_valid <= 1'b1;
		pix <= p;
		pending_hls.push_back(want);
		@(posedge clk);
		while (pix_stall)
			@(posedge clk);
	endtask

	function automatic pix_t random_pixel();
		pix_t p;
		int sel;
		sel = $urandom_range(9);
		p = pix_t'(48'({$urandom, $urandom}));
		case (sel)
			0: p.green_in = p.red_in;
			1: p.blue_in = p.green_in;
			2: begin
				p.green_in = p.red_in;
				p.blue_in = p.red_in;
			end
			3: p.blue_in = p.red_in;
			4: begin
				p.red_in = 16'hFFFF;
				p.blue_in = 16'(p.blue_in & 16'h00FF);
			end
			5: begin
				p.green_in = 16'(p.red_in + $urandom_range(3));
				p.blue_in = 16'(p.red_in - $urandom_range(3));
			end
			default: ;
		endcase
		return p;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			res_stall <= take_gap();
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (pending_hls.size() == 0) begin
				$display("%0t unexpected result: actual %p", $time, res);
				n_fail++;
			end else begin
				res_t want;
				want = pending_hls.pop_front();
				if (res.hue_out !== want.hue_out) begin
					$display("%0t hue mismatch: expected %0d actual %0d",
						$time, want.hue_out, res.hue_out);
					n_fail++;
				end
				if (res.light_out !== want.light_out) begin
					$display("%0t lightness mismatch: expected %0d actual %0d",
						$time, want.light_out, res.light_out);
					n_fail++;
				end
				if (res.sat_out !== want.sat_out) begin
					$display("%0t saturation mismatch: expected %0d actual %0d",
						$time, want.sat_out, res.sat_out);
					n_fail++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((pix_valid && !pix_stall) || (res_valid && !res_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchdogLimit) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		pix_t p;
		res_t want;
		no_idle = 1'b0;
		arst_n = 1'b0;
		pix_valid = 1'b0;
		pix = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < NumDirected; i++) begin
			want = dir_tab[i].known ? dir_tab[i].r : convert_hls(dir_tab[i].p);
			send_pixel(dir_tab[i].p, want);
		end
		for (int i = 0; i < NumRandom; i++) begin
			if (i == 300)
				no_idle = 1'b1;
			if (i == 500)
				no_idle = 1'b0;
			if (i == 700) begin
				pix_valid <= 1'b0;
				while (pending_hls.size() != 0)
					@(posedge clk);
			end
			p = random_pixel();
			send_pixel(p, convert_hls(p));
		end
		pix_valid <= 1'b0;
		while (pending_hls.size() != 0)
			@(posedge clk);
		repeat (LatencyCycles + 5) @(posedge clk);
		if (n_fail == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ rgb_to_hls_convert_top.f @@
hw/rtl/rgbhls_pkg.sv
hw/rtl/rgbhls_div_cell.sv
hw/rtl/rgb_to_hls_convert_top.sv
hw/rtl/rgbhls_checker.sv
tb/sv/tb_rgb_to_hls_convert_top.sv
